/* hdl/cmrc_pkg.sv */
// Package for the complement-class row counter: request payload types,
// token control flags shared by the cells and the top level, fixed constants.
// No dependencies.
package cmrc_pkg;

	localparam int ROW_W       = 64;
	localparam int CFG_W       = 7;
	localparam int BEST_W      = 9;
	localparam logic [CFG_W-1:0]  ROW_LEN_RESET = 7'd64;
	localparam logic [BEST_W-1:0] BEST_SAT      = 9'd511;

	// One row request
	typedef struct packed {
		logic [ROW_W-1:0] row_bits;
		logic             first_row;
	} row_in_t;

	// One result request
	typedef struct packed {
		logic [BEST_W-1:0] best_count;
		logic              overflow;
	} row_out_t;

	// Control flags of a row token as it travels down the cell chain
	typedef struct packed {
		logic vld;   // slot holds a row
		logic clr;   // row starts a new matrix: cells drop their entries
		logic drop;  // row dropped, table full
		logic done;  // row already matched or placed
	} tok_ctl_t;

endpackage

/* hdl/cmrc_cell.sv */
// One table cell of the chain: holds one pattern, its count and valid bit,
// and passes the row token on to the next cell. Depends on cmrc_pkg.
module cmrc_cell import cmrc_pkg::*; #(
	parameter int KW = 64,
	parameter int CW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tok_ctl_t      in_ctl,
	input  logic [KW-1:0] in_key,
	input  logic [CW-1:0] in_cnt,
	output tok_ctl_t      out_ctl,
	output logic [KW-1:0] out_key,
	output logic [CW-1:0] out_cnt
);

	logic          valid_q;
	logic [KW-1:0] key_q;
	logic [CW-1:0] cnt_q;

	tok_ctl_t      ctl_s1;
	logic [KW-1:0] key_s1;
	logic [CW-1:0] cnt_s1;

	logic          live;
	logic          held;
	logic          hit;
	logic          claim;
	logic [CW-1:0] nxt_cnt;
	tok_ctl_t      ctl_nxt;

	// Match or claim this entry
	always_comb begin
		live    = in_ctl.vld && !in_ctl.drop && !in_ctl.done;
		held    = valid_q && !(in_ctl.vld && in_ctl.clr);
		hit     = live && held && (key_q == in_key);
		claim   = live && !held;
		nxt_cnt = hit ? cnt_q + CW'(1) : CW'(1);
		ctl_nxt      = in_ctl;
		ctl_nxt.done = in_ctl.done || hit || claim;
	end

	// Entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= held || claim;
		end
	end

	// Entry pattern and count
	always_ff @(posedge clk) begin
		if (en && claim) begin
			key_q <= in_key;
		end
		if (en && (hit || claim)) begin
			cnt_q <= nxt_cnt;
		end
	end

	// Token control stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_nxt;
		end
	end

	// Token payload stage
	always_ff @(posedge clk) begin
		if (en) begin
			key_s1 <= in_key;
			cnt_s1 <= (hit || claim) ? nxt_cnt : in_cnt;
		end
	end

	assign out_ctl = ctl_s1;
	assign out_key = key_s1;
	assign out_cnt = cnt_s1;

endmodule

/* hdl/complement_class_row_mode_counter.sv */
// Complement-class row counter. Takes one row per cycle and returns one result per
// row: the row travels down a chain of MAX_ROWS cells, one cell a cycle; each cell
// holds one stored pattern with its count, and the result is registered. A row
// and its complement (within row_length columns) count as one class; best_count
// is the largest class count of the current matrix, first_row starts a new one.
// Rows after MAX_ROWS in one matrix are dropped with overflow set. The whole chain
// stalls while a result waits on out_ready. Depends on cmrc_pkg and cmrc_cell.
module complement_class_row_mode_counter import cmrc_pkg::*; #(
	parameter int MAX_ROWS = 256,
	parameter int ROW_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  row_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output row_out_t         out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int BW = (CW > BEST_W) ? CW : BEST_W;

	logic [CFG_W-1:0] row_length_q;
	logic [CW-1:0]    rows_seen_q;
	logic [CW-1:0]    best_q;
	logic             out_valid_q;
	row_out_t         out_data_q;

	logic                en;
	logic                accept;
	logic [CFG_W-1:0]    len_c;
	logic [ROW_BITS-1:0] mask;
	logic [ROW_BITS-1:0] key_raw;
	logic [ROW_BITS-1:0] key_c;
	logic [CW-1:0]       rows_base;
	logic                drop_c;

	tok_ctl_t            ctl_chain [0:MAX_ROWS];
	logic [ROW_BITS-1:0] key_chain [0:MAX_ROWS];
	logic [CW-1:0]       cnt_chain [0:MAX_ROWS];

	tok_ctl_t            tail_ctl;
	logic [CW-1:0]       tail_cnt;
	logic [CW-1:0]       best_nxt;
	logic [BW-1:0]       best_ext;

	// Advance the chain whenever the output register can take a result
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	// Row length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LEN_RESET;
		end else if (cfg_we) begin
			row_length_q <= cfg_wdata;
		end
	end

	// Clamp the length, mask the row and fold it onto its canonical form
	always_comb begin
		len_c = row_length_q;
		if (len_c == '0) begin
			len_c = CFG_W'(1);
		end
		if (len_c > CFG_W'(ROW_BITS)) begin
			len_c = CFG_W'(ROW_BITS);
		end
		for (int j = 0; j < ROW_BITS; j++) begin
			mask[j] = (CFG_W'(j) < len_c);
		end
		key_raw = in_data.row_bits[ROW_BITS-1:0] & mask;
		key_c   = key_raw[0] ? (~key_raw & mask) : key_raw;
	end

	// Decide overflow at entry from the row count of the current matrix
	always_comb begin
		rows_base = in_data.first_row ? '0 : rows_seen_q;
		drop_c    = (rows_base >= CW'(MAX_ROWS));
	end

	// Row count of the current matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_seen_q <= '0;
		end else if (accept) begin
			rows_seen_q <= drop_c ? rows_base : rows_base + CW'(1);
		end
	end

	// Head of the chain: a row or a bubble
	always_comb begin
		ctl_chain[0].vld  = accept;
		ctl_chain[0].clr  = in_data.first_row;
		ctl_chain[0].drop = drop_c;
		ctl_chain[0].done = 1'b0;
		key_chain[0]      = key_c;
		cnt_chain[0]      = '0;
	end

	// Chain of table cells
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		cmrc_cell #(
			.KW (ROW_BITS),
			.CW (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_ctl  (ctl_chain[i]),
			.in_key  (key_chain[i]),
			.in_cnt  (cnt_chain[i]),
			.out_ctl (ctl_chain[i+1]),
			.out_key (key_chain[i+1]),
			.out_cnt (cnt_chain[i+1])
		);
	end

	assign tail_ctl = ctl_chain[MAX_ROWS];
	assign tail_cnt = cnt_chain[MAX_ROWS];

	// Track the best count at the end of the chain
	always_comb begin
		best_nxt = tail_ctl.clr ? '0 : best_q;
		if (tail_ctl.done && (tail_cnt > best_nxt)) begin
			best_nxt = tail_cnt;
		end
		best_ext = BW'(best_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tail_ctl.vld;
			if (tail_ctl.vld) begin
				best_q <= best_nxt;
			end
		end
	end

	// Result register, saturate the reported count
	always_ff @(posedge clk) begin
		if (en && tail_ctl.vld) begin
			out_data_q.best_count <= (best_ext > BW'(BEST_SAT)) ? BEST_SAT
			                                                     : best_ext[BEST_W-1:0];
			out_data_q.overflow   <= tail_ctl.drop;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* hdl/cmrc_checker.sv */
// Port-level checks for the complement-class row counter, bound to the top level.
// Depends on cmrc_pkg and complement_class_row_mode_counter.
module cmrc_checker import cmrc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input row_out_t out_data
);

	// Hold a stalled result request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Accept rows exactly when the output side can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// Every matrix holds at least one counted row by the time a result shows
	a_best_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.best_count != '0)
		else $error("zero best count reported");

	// A presented result carries no unknown bits
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data))
		else $error("unknown bits in result");

endmodule

bind complement_class_row_mode_counter cmrc_checker u_cmrc_checker (.*);

/* bench/cmrc_result_checker.sv */
// Result checker for the complement-class row counter: follows the row and result
// channels and the row_length register, predicts each result and compares it.
// Depends on cmrc_pkg.
`timescale 1ns / 1ps

module cmrc_result_checker import cmrc_pkg::*; #(
	parameter int MAX_ROWS = 256,
	parameter int ROW_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  row_in_t          in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  row_out_t         out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               pending
);

	// Own copy of the class table and matrix state
	logic [ROW_W-1:0]  class_key   [MAX_ROWS];
	logic [BEST_W-1:0] class_count [MAX_ROWS];
	int                classes_used;
	int                rows_in_matrix;
	logic [BEST_W-1:0] best_class;
	logic [CFG_W-1:0]  row_len;

	row_out_t predicted_results[$];
	row_out_t oldest;
	int       results_seen;

	// Work out the result of one row and update the table
	function automatic row_out_t count_row_class(row_in_t req);
		int               len;
		int               hit;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] key;
		row_out_t         res;

		len = row_len;
		if (len == 0)
			len = 1;
		if (len > ROW_BITS)
			len = ROW_BITS;
		mask = (len >= ROW_W) ? '1 : ((64'd1 << len) - 64'd1);
		key  = req.row_bits & mask;
		if (key[0])
			key = ~key & mask;

		if (req.first_row) begin
			classes_used   = 0;
			rows_in_matrix = 0;
			best_class     = '0;
		end

		res.overflow = 1'b0;
		if (rows_in_matrix >= MAX_ROWS) begin
			res.overflow = 1'b1;
		end else begin
			hit = -1;
			for (int i = 0; i < classes_used; i++) begin
				if (hit < 0 && class_key[i] == key)
					hit = i;
			end
			if (hit >= 0) begin
				class_count[hit] = class_count[hit] + 1'b1;
				if (class_count[hit] > best_class)
					best_class = class_count[hit];
			end else begin
				class_key[classes_used]   = key;
				class_count[classes_used] = BEST_W'(1);
				classes_used++;
				if (best_class < 1)
					best_class = BEST_W'(1);
			end
			rows_in_matrix++;
		end
		res.best_count = (best_class > BEST_SAT) ? BEST_SAT : best_class;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: result %0d: %s is %0d, expected %0d", $realtime, results_seen, what,
			got, want);
		mismatches++;
	endtask

	// Compare results against the oldest prediction, queue new ones, track the register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classes_used   = 0;
			rows_in_matrix = 0;
			best_class     = '0;
			row_len        = ROW_LEN_RESET;
			results_seen   = 0;
			predicted_results.delete();
			pending        = 0;
			mismatches     = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result, best_count", out_data.best_count, 0);
				end else begin
					oldest = predicted_results.pop_front();
					if (out_data.best_count !== oldest.best_count)
						report_mismatch("best_count", out_data.best_count, oldest.best_count);
					if (out_data.overflow !== oldest.overflow)
						report_mismatch("overflow", out_data.overflow, oldest.overflow);
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				predicted_results.insert(predicted_results.size(), count_row_class(in_data));
			if (cfg_we)
				row_len = cfg_wdata;
			pending = predicted_results.size();
		end
	end

endmodule

/* bench/complement_class_row_mode_counter_tb.sv */
// Top of the complement-class row counter bench: clock, reset, row stimulus,
// result-side stalls and the verdict. Depends on cmrc_pkg, the block and cmrc_result_checker.
`timescale 1ns / 1ps

module complement_class_row_mode_counter_tb;
	import cmrc_pkg::*;

	localparam int MAX_ROWS = 256;
	localparam int ROW_BITS = 64;
	localparam int DRAIN_CYCLES = MAX_ROWS + 40;
	localparam int LONG_HOLD = 400;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	row_in_t          in_data;
	logic             out_valid;
	logic             out_ready;
	row_out_t         out_data;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	int               mismatches;
	int               pending;

	logic bursty;
	logic hold_out;
	int   eff_len;
	int   plan_len [8] = '{1, 2, 33, 64, 63, 7, 100, 0};

	complement_class_row_mode_counter #(
		.MAX_ROWS (MAX_ROWS),
		.ROW_BITS (ROW_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cmrc_result_checker #(
		.MAX_ROWS (MAX_ROWS),
		.ROW_BITS (ROW_BITS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Offer one row, hold it until taken, then idle for a burst now and then
	task automatic send_row(input logic [ROW_W-1:0] bits, input logic first);
		in_data.row_bits  = bits;
		in_data.first_row = first;
		in_valid          = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Wait for every outstanding result, then write row_length
	task automatic set_row_length(input logic [CFG_W-1:0] value);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		eff_len = (value == 0) ? 1 : (value > ROW_BITS) ? ROW_BITS : value;
	endtask

	// Send matrices built from a few patterns, their complements and junk above the length
	task automatic run_matrices(input int n_rows, input int min_size, input int max_size,
			input int noise_pct, input int hold_at);
		int               sent;
		int               size;
		int               k;
		logic [ROW_W-1:0] pool [8];
		logic [ROW_W-1:0] bits;
		logic             first;

		sent = 0;
		while (sent < n_rows) begin
			size = $urandom_range(min_size, max_size);
			if (size > n_rows - sent)
				size = n_rows - sent;
			k = $urandom_range(1, 8);
			for (int i = 0; i < k; i++)
				pool[i] = {$urandom, $urandom};
			for (int r = 0; r < size; r++) begin
				if ($urandom_range(0, 99) < noise_pct) begin
					bits = {$urandom, $urandom};
				end else begin
					bits = pool[$urandom_range(0, k - 1)];
					if ($urandom_range(0, 1))
						bits = ~bits;
					if ($urandom_range(0, 2) == 0)
						bits = bits ^ ({$urandom, $urandom} << eff_len);
				end
				first = (r == 0) && ($urandom_range(0, 7) != 0);
				if (sent == hold_at)
					hold_out = 1'b1;
				send_row(bits, first);
				sent++;
			end
		end
	endtask

	// Result side: random stall bursts, and one long hold to back up the chain
	initial begin : p_receiver
		logic hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out && !hold_done) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end else if (bursty && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		bursty    = 1'b1;
		hold_out  = 1'b0;
		eff_len   = ROW_BITS;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Full width: no matrix start after reset, all-zero and all-one rows, complements
		send_row(64'h0, 1'b0);
		send_row('1, 1'b1);
		send_row(64'h0, 1'b0);
		send_row(64'h8000_0000_0000_0000, 1'b0);
		send_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_row(64'h5555_5555_5555_5555, 1'b0);
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_row(64'h0000_0000_0000_0001, 1'b0);
		send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);

		// Zero length acts as one column: every row lands in one class
		set_row_length('0);
		send_row({$urandom, $urandom}, 1'b1);
		send_row({$urandom, $urandom}, 1'b0);
		send_row({$urandom, $urandom}, 1'b0);
		send_row({$urandom, $urandom}, 1'b1);
		send_row({$urandom, $urandom}, 1'b0);

		// Length above the row width acts as full width
		set_row_length('1);
		send_row(64'hF000_0000_0000_0000, 1'b1);
		send_row(64'h0FFF_FFFF_FFFF_FFFF, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b0);

		// Random matrices over a spread of lengths; one long matrix overflows the table
		for (int p = 0; p < 8; p++) begin
			if (p == 7) begin
				bursty = 1'b0;
				set_row_length(CFG_W'($urandom_range(1, ROW_BITS)));
			end else begin
				set_row_length(CFG_W'(plan_len[p]));
			end
			if (plan_len[p] == ROW_BITS)
				run_matrices(270, 270, 270, 40, 120);
			else
				run_matrices(40, 1, 30, 20, -1);
		end

		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
